// File: hw/rtl/lkt_pkg.sv
// Shared types and sizing constants for the LRU key tracker.
package lkt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_W       = 32;
	localparam int CAP_W       = 5;
	localparam int OCC_W       = 5;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cap;
	} lkt_req_t;

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
		logic [CNT_W-1:0] occupancy;
	} lkt_rsp_t;

endpackage

// File: hw/rtl/lkt_stack.sv
// Recency stack with parallel key compare and one-position shift update.
module lkt_stack
	import lkt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  lkt_req_t req,
	output lkt_rsp_t rsp
);

	logic [KEY_W-1:0] stack_q [MAX_ENTRIES];
	logic [KEY_W-1:0] stack_d [MAX_ENTRIES];
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	logic [CNT_W-1:0] fill_m1;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] limit;
	logic             hit;
	logic             evict;

	assign fill_m1 = fill_q - CNT_W'(1);

	// Lowest matching position among the occupied entries.
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!hit && (CNT_W'(i) < fill_q) && (stack_q[i] == req.key)) begin
				hit = 1'b1;
				pos = CNT_W'(i);
			end
		end
	end

	assign evict = !hit && (fill_q >= req.cap);

	// Entries at or below the limit take their upper neighbor.
	always_comb begin
		if (hit) begin
			limit = pos;
		end else if (evict) begin
			limit = fill_m1;
		end else begin
			limit = fill_q;
		end
		stack_d[0] = req.key;
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			stack_d[i] = (CNT_W'(i) <= limit) ? stack_q[i-1] : stack_q[i];
		end
	end

	assign fill_d = (!hit && !evict) ? fill_q + CNT_W'(1) : fill_q;

	always_ff @(posedge clk) begin
		if (req.vld) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				stack_q[i] <= stack_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (req.vld) begin
			fill_q <= fill_d;
		end
	end

	always_comb begin
		rsp.hit         = hit;
		rsp.evicted     = evict;
		rsp.evicted_key = evict ? stack_q[fill_m1[IDX_W-1:0]] : '0;
		rsp.occupancy   = fill_d;
	end

endmodule

// File: hw/rtl/lru_key_tracker_top.sv
// Top level of the LRU key tracker: input stage, capacity register and result stage.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  access  | start, key (busy is out)                  | in
//  result  | done, hit, evicted, evicted_key, occupancy| out
//  config  | cfg_we, cfg_wdata (capacity)              | in
//
// One key is taken per clock cycle; busy is never raised because the stack
// update for one beat completes combinationally between the input register
// and the result register. An accepted beat is captured in the input register
// and then in the result register, which raises done with its result.
// Reset clears the fill count and sets capacity to 16; stack contents are not
// cleared, since only entries below the fill count are ever compared or read.
// The receiver cannot stall: each result is present for exactly one cycle.
module lru_key_tracker_top
	import lkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [KEY_W-1:0] key,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output logic             hit,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key,
	output logic [OCC_W-1:0] occupancy
);

	logic             vld_s1;
	logic [KEY_W-1:0] key_s1;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] cap_eff;
	lkt_req_t         req;
	lkt_rsp_t         rsp;
	logic             done_q;
	logic             hit_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evicted_key_q;
	logic [OCC_W-1:0] occupancy_q;

	// The tracker always keeps pace with the sender.
	assign busy = 1'b0;

	// Capacity register. A zero setting acts as one entry, and anything above
	// the stack depth saturates to the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > 32'(MAX_ENTRIES)) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_s1 <= key;
		end
	end

	always_comb begin
		req.vld = vld_s1;
		req.key = key_s1;
		req.cap = cap_eff;
	end

	lkt_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Result register: the strobe is reset, the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q         <= rsp.hit;
			evicted_q     <= rsp.evicted;
			evicted_key_q <= rsp.evicted_key;
			occupancy_q   <= OCC_W'(rsp.occupancy);
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign occupancy   = occupancy_q;

`ifndef NO_ASSERTIONS
	// A beat is either a hit or a miss, so it never both hits and evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted))
		else $error("hit and eviction reported on the same beat");

	// Without an eviction the evicted key reads as zero.
	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted) |-> (evicted_key == '0))
		else $error("evicted key nonzero without eviction");

	// Every access leaves at least the accessed key tracked.
	a_occ_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupancy != '0))
		else $error("occupancy zero after an access");

	// An accepted beat always produces a result, after the input and result registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted beat produced no result");
`endif

endmodule

// File: sim/lru_key_tracker_top_test.sv
// Self-checking testbench for the LRU key tracker top level.
module lru_key_tracker_top_test;
	import lkt_pkg::*;

	// Clock, reset and the block's inputs. Every input holds a known value from time zero.
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic [KEY_W-1:0] key       = '0;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	logic             busy;
	logic             done;
	logic             hit;
	logic             evicted;
	logic [KEY_W-1:0] evicted_key;
	logic [OCC_W-1:0] occupancy;

	lru_key_tracker_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key         (key),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.hit         (hit),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.occupancy   (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Keys waiting to be offered, filled by the stimulus block and drained by the driver.
	logic [KEY_W-1:0] key_backlog[$];
	// Predicted outcome of every accepted beat whose result has not come back yet.
	lkt_rsp_t         pending_outcomes[$];

	// Our own copy of the tracker: recency stack (slot 0 is the most recent key),
	// the number of live slots and the capacity register as the block sees it.
	logic [KEY_W-1:0] lru_stack[MAX_ENTRIES];
	int               lru_fill;
	logic [CAP_W-1:0] shadow_cap;

	// Bookkeeping. The accepted and result counters only move at the rising edge, so the stimulus
	// block can read them at the falling edge without racing the driver.
	bit               took_beat  = 1'b0;
	bit               steady_run = 1'b0;
	int               beats_queued   = 0;
	int               beats_accepted = 0;
	int               results_seen   = 0;
	int               hits_seen      = 0;
	int               evictions_seen = 0;
	int               cap_writes     = 0;
	int               failures       = 0;

	// Applies one access to the copy of the tracker and returns the result the block
	// should report for it. A hit moves the key to the front; a miss pushes it at the
	// front and, once the tracker is full, drops the least recent key. A capacity of
	// zero acts as one and anything above the stack depth acts as the full depth.
	// When the capacity has been lowered below the current fill, misses keep evicting
	// so the fill never grows back and never shrinks either.
	function automatic lkt_rsp_t track_access(input logic [KEY_W-1:0] k);
		lkt_rsp_t r;
		int       limit;
		int       pos;
		int       depth;
		r     = '0;
		limit = shadow_cap;
		if (limit == 0)
			limit = 1;
		if (limit > MAX_ENTRIES)
			limit = MAX_ENTRIES;
		// The lowest matching slot wins, although a key can never sit in two slots.
		pos = -1;
		for (int i = 0; i < lru_fill; i++)
			if (pos < 0 && lru_stack[i] == k)
				pos = i;
		if (pos >= 0) begin
			r.hit = 1'b1;
			depth = pos;
		end else if (lru_fill >= limit) begin
			r.evicted     = 1'b1;
			r.evicted_key = lru_stack[lru_fill-1];
			depth         = lru_fill - 1;
		end else begin
			depth = lru_fill;
			lru_fill++;
		end
		// Everything above the chosen depth slides down one slot, then the key goes on top.
		for (int i = depth; i > 0; i--)
			lru_stack[i] = lru_stack[i-1];
		lru_stack[0] = k;
		r.occupancy  = CNT_W'(lru_fill);
		return r;
	endfunction

	// Driver: presents one key at a time and moves on once the beat has been taken.
	// On about six percent of its turns it idles instead, except during the steady
	// stretch, where it keeps start high back to back.
	always @(negedge clk) begin
		if (!start || took_beat) begin
			if (key_backlog.size() != 0 && (steady_run || $urandom_range(0, 99) >= 6)) begin
				start <= 1'b1;
				key   <= key_backlog.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predicts every accepted beat, tracks capacity writes as the block takes
	// them, and checks each result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		lkt_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++)
				lru_stack[i] = '0;
			lru_fill   = 0;
			shadow_cap = CAP_RESET;
			took_beat  = 1'b0;
		end else begin
			took_beat = start && !busy;
			if (took_beat) begin
				pending_outcomes.push_back(track_access(key));
				beats_accepted++;
			end
			if (cfg_we)
				shadow_cap = cfg_wdata;
			if (done) begin
				results_seen++;
				hits_seen      += hit;
				evictions_seen += evicted;
				if (pending_outcomes.size() == 0) begin
					$error("result beat with nothing outstanding: hit=%0b evicted=%0b occupancy=%0d",
						hit, evicted, occupancy);
					failures++;
				end else begin
					want = pending_outcomes.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, hit);
						failures++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0b, got %0b", want.evicted, evicted);
						failures++;
					end
					if (evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected %08h, got %08h", want.evicted_key,
							evicted_key);
						failures++;
					end
					if (occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
						failures++;
					end
				end
			end
		end
	end

	task automatic queue_key(input logic [KEY_W-1:0] k);
		key_backlog.push_back(k);
		beats_queued++;
	endtask

	// Capacity is only ever written here, and only once the tracker has gone quiet.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cap_writes++;
	endtask

	// Waits until every queued key has been accepted and every result has returned,
	// with a bound, then keeps waiting to catch any stray result beat.
	task automatic settle();
		int waited;
		waited = 0;
		while ((beats_accepted != beats_queued || pending_outcomes.size() != 0) && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
		if (pending_outcomes.size() != 0) begin
			$error("%0d result beats never arrived", pending_outcomes.size());
			failures++;
			pending_outcomes.delete();
		end
	endtask

	// Stimulus: a short directed part, then phases of random accesses, each phase under
	// its own capacity and drawing most keys from a small working set so that hits,
	// reorders and evictions are frequent.
	initial begin
		logic [KEY_W-1:0] pool[$];
		int               pool_size;
		int               pick;
		logic [KEY_W-1:0] k;
		logic [CAP_W-1:0] cap_value;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity: all-zero and all-ones keys, a hit one slot down, a hit three
		// slots down and a hit on the top slot.
		queue_key(32'h0000_0000);
		queue_key(32'hFFFF_FFFF);
		queue_key(32'h0000_0000);
		queue_key(32'h5555_5555);
		queue_key(32'hAAAA_AAAA);
		queue_key(32'hFFFF_FFFF);
		queue_key(32'h8000_0000);
		queue_key(32'h0000_0001);
		queue_key(32'h0000_0001);
		settle();

		// Capacity lowered below the fill: misses evict while the fill holds at six.
		write_capacity(CAP_W'(2));
		queue_key(32'h1234_5678);
		queue_key(32'h9ABC_DEF0);
		queue_key(32'h0000_0001);
		queue_key(32'h1234_5678);
		settle();

		// Zero capacity behaves like a capacity of one.
		write_capacity(CAP_W'(0));
		queue_key(32'hFFFF_0000);
		queue_key(32'hFFFF_0000);
		queue_key(32'h0000_FFFF);
		settle();

		// Capacity above the stack depth saturates, so misses grow the fill again.
		write_capacity(CAP_W'(31));
		queue_key(32'h0000_FFFF);
		queue_key(32'hDEAD_BEEF);
		queue_key(32'h0000_0000);
		settle();

		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0:       cap_value = CAP_W'(1);
				1:       cap_value = CAP_W'(16);
				2:       cap_value = CAP_W'(0);
				3:       cap_value = CAP_W'(31);
				4:       cap_value = CAP_W'(3);
				default: cap_value = CAP_W'($urandom_range(0, 31));
			endcase
			write_capacity(cap_value);
			// Two phases run with no idle gaps at all.
			steady_run = (phase == 5 || phase == 6);

			// Working set: random full-width keys mixed with keys near zero and near
			// all-ones, sometimes smaller and sometimes larger than the capacity.
			pool.delete();
			pool_size = $urandom_range(1, 24);
			for (int i = 0; i < pool_size; i++) begin
				case ($urandom_range(0, 3))
					0:       pool.push_back(KEY_W'($urandom_range(0, 15)));
					1:       pool.push_back(~KEY_W'($urandom_range(0, 15)));
					default: pool.push_back($urandom);
				endcase
			end

			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					k = pool[$urandom_range(0, pool.size() - 1)];
				else if (pick < 90)
					// One bit away from a working-set key, to exercise the full-width compare.
					k = pool[$urandom_range(0, pool.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
				else
					k = $urandom;
				queue_key(k);
			end
			settle();
		end
		steady_run = 1'b0;

		$display("Covered %0d accesses (%0d results, %0d hits, %0d evictions) under %0d capacity writes,",
			beats_accepted, results_seen, hits_seen, evictions_seen, cap_writes);
		$display("including zero, saturating and lowered-below-fill capacities.");
		if (failures == 0) begin
			$display("lru_key_tracker_top_test: PASS");
		end else begin
			$display("lru_key_tracker_top_test: FAIL");
		end
		$finish;
	end

	// Watchdog: a correct run finishes in well under a tenth of this.
	initial begin
		#2000000;
		$display("lru_key_tracker_top_test: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lkt_pkg.sv
hw/rtl/lkt_stack.sv
hw/rtl/lru_key_tracker_top.sv
sim/lru_key_tracker_top_test.sv
